// ----- hdl/perlin_noise_3d_defines.svh -----
//------------------------------------------------------------------------------
// perlin_noise_3d_defines
// Assertion macros for the perlin noise block.
//------------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_DEFINES_SVH
`define PERLIN_NOISE_3D_DEFINES_SVH
// property that holds in every cycle out of reset
`define PN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the following cycle
`define PN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/pn3d_pkg.sv -----
//------------------------------------------------------------------------------
// pn3d_pkg
// Shared constants, types and ROM functions for the 3D noise pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pn3d_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int OUT_W     = 18;
    localparam int FW        = FRAC_BITS + 2;   // signed offset / gradient width
    localparam int GW        = FRAC_BITS + 3;   // gradient result width
    localparam int LW        = FRAC_BITS + 6;   // blend working width

    typedef logic [7:0] t_byte;
    typedef logic [FRAC_BITS-1:0] t_frac;

    // LCG swap shuffle of the identity, folded at elaboration
    function automatic t_byte perm_at(input logic [7:0] idx);
        logic [7:0] p [256];
        logic [7:0] tmp;
        logic [31:0] j;
        for (int i = 0; i < 256; i++) p[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j = 32'(i) * 32'd1103515245 + 32'd12345;
            tmp = p[i];
            p[i] = p[j[7:0]];
            p[j[7:0]] = tmp;
        end
        return p[idx];
    endfunction

    // gradient dot product for one corner
    function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
            input logic signed [FW-1:0] x, input logic signed [FW-1:0] y,
            input logic signed [FW-1:0] z);
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        u = (h < 4'd8) ? GW'(x) : GW'(y);
        v = (h < 4'd4) ? GW'(y) : ((h == 4'd12 || h == 4'd14) ? GW'(x) : GW'(z));
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction
endpackage
`default_nettype wire

// ----- hdl/pn3d_fade.sv -----
//------------------------------------------------------------------------------
// pn3d_fade
// Quintic fade curve over three registered stages, with stall enable.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pn3d_fade (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire pn3d_pkg::t_frac      i_t,
    output logic [pn3d_pkg::FRAC_BITS:0] o_fade
);
    localparam int F = pn3d_pkg::FRAC_BITS;
    logic [F-1:0] r_t2;
    logic [F+3:0] r_q;
    logic [F-1:0] r_sq;
    logic [F-1:0] r_cube;
    logic [F+3:0] r_q2;
    logic [F+3:0] n_q;
    logic [2*F+2:0] w_p6;
    logic [2*F-1:0] w_sq, w_cube;
    logic [2*F+3:0] w_f;

    // stage 1: t^2 and q = 6t^2 - 15t + 10, straight from the input
    assign w_sq = i_t * i_t;
    assign w_p6 = (2*F+3)'(w_sq) * (2*F+3)'(6);
    assign n_q  = (F+4)'(w_p6 >> F) + (F+4)'(10) * (F+4)'(1 << F)
                - (F+4)'(15) * (F+4)'(i_t);
    assign w_cube = r_sq * r_t2;
    assign w_f = (2*F+4)'(r_cube) * (2*F+4)'(r_q2);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_sq   <= w_sq[2*F-1:F];
            r_t2   <= i_t;
            r_cube <= w_cube[2*F-1:F];
            r_q2   <= r_q;
            o_fade <= (F+1)'(w_f >> F);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/perlin_noise_3d.sv -----
//------------------------------------------------------------------------------
// perlin_noise_3d
// Improved Perlin gradient noise on Q16.16 points, fully pipelined.
//------------------------------------------------------------------------------
// One point enters per cycle unless the pipe is stalled, and one noise value
// leaves per point, in order. Seven register stages: S1 cell hash A/B, S2
// corner hashes AA..BB, S3 corner gradients, fade (3 stages in parallel
// with S1..S3), S4 x blend, S5 y blend, S6 z blend, S7 clamp into the output
// register. A stall freezes the whole pipe; the input side stalls in every
// cycle in which the output register holds an untaken beat, whether or not
// the pipe behind it is full. The permutation is a constant ROM read
// combinationally.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module perlin_noise_3d (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [17:0]      o_noise_value
);
    localparam int F  = pn3d_pkg::FRAC_BITS;
    localparam int FW = pn3d_pkg::FW;
    localparam int GW = pn3d_pkg::GW;
    localparam int LW = pn3d_pkg::LW;
    localparam int NS = 7;

    logic [NS-1:0] r_vld;
    logic          w_en;
    // pipe advances unless the output beat is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NS-1];

    // S1
    logic [7:0] r1_y, r1_z, r1_a, r1_b;
    logic [F-1:0] r1_x, r1_yf, r1_zf;
    // S2
    logic [7:0] r2_aa, r2_ab, r2_ba, r2_bb;
    logic [F-1:0] r2_x, r2_y, r2_z;
    // S3
    logic signed [GW-1:0] r3_g [8];
    // S4..S6
    logic signed [LW-1:0] r4_l [4];
    logic signed [LW-1:0] r5_l [2];
    logic signed [LW-1:0] r6_l;
    logic [F:0] w_fx, w_fy, w_fz;
    logic [F:0] r4_fy, r4_fz, r5_fz;

    pn3d_fade u_fx (.i_clk(i_clk), .i_en(w_en), .i_t(i_coord_x[F-1:0]), .o_fade(w_fx));
    pn3d_fade u_fy (.i_clk(i_clk), .i_en(w_en), .i_t(i_coord_y[F-1:0]), .o_fade(w_fy));
    pn3d_fade u_fz (.i_clk(i_clk), .i_en(w_en), .i_t(i_coord_z[F-1:0]), .o_fade(w_fz));

    function automatic logic signed [LW-1:0] lerp(input logic signed [LW-1:0] a,
            input logic signed [LW-1:0] b, input logic [F:0] w);
        logic signed [LW+F+2:0] m;
        m = (LW+F+3)'(signed'({1'b0, w})) * (LW+F+3)'(b - a);
        return a + LW'(m >>> F);
    endfunction

    logic signed [FW-1:0] w_x0, w_x1, w_y0, w_y1, w_z0, w_z1;
    logic [7:0] w_c [8];
    assign w_x0 = FW'({2'b00, r2_x});
    assign w_y0 = FW'({2'b00, r2_y});
    assign w_z0 = FW'({2'b00, r2_z});
    assign w_x1 = w_x0 - FW'(1 << F);
    assign w_y1 = w_y0 - FW'(1 << F);
    assign w_z1 = w_z0 - FW'(1 << F);
    assign w_c[0] = pn3d_pkg::perm_at(r2_aa);
    assign w_c[1] = pn3d_pkg::perm_at(r2_ba);
    assign w_c[2] = pn3d_pkg::perm_at(r2_ab);
    assign w_c[3] = pn3d_pkg::perm_at(r2_bb);
    assign w_c[4] = pn3d_pkg::perm_at(r2_aa + 8'd1);
    assign w_c[5] = pn3d_pkg::perm_at(r2_ba + 8'd1);
    assign w_c[6] = pn3d_pkg::perm_at(r2_ab + 8'd1);
    assign w_c[7] = pn3d_pkg::perm_at(r2_bb + 8'd1);

    logic signed [LW-1:0] w_r;
    assign w_r = lerp(r5_l[0], r5_l[1], r5_fz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a  <= pn3d_pkg::perm_at(i_coord_x[F+7:F]) + i_coord_y[F+7:F];
            r1_b  <= pn3d_pkg::perm_at(i_coord_x[F+7:F] + 8'd1) + i_coord_y[F+7:F];
            r1_z  <= i_coord_z[F+7:F];
            r1_y  <= i_coord_y[F+7:F];
            r1_x  <= i_coord_x[F-1:0];
            r1_yf <= i_coord_y[F-1:0];
            r1_zf <= i_coord_z[F-1:0];
            r2_aa <= pn3d_pkg::perm_at(r1_a) + r1_z;
            r2_ab <= pn3d_pkg::perm_at(r1_a + 8'd1) + r1_z;
            r2_ba <= pn3d_pkg::perm_at(r1_b) + r1_z;
            r2_bb <= pn3d_pkg::perm_at(r1_b + 8'd1) + r1_z;
            r2_x  <= r1_x;
            r2_y  <= r1_yf;
            r2_z  <= r1_zf;
            r3_g[0] <= pn3d_pkg::grad(w_c[0][3:0], w_x0, w_y0, w_z0);
            r3_g[1] <= pn3d_pkg::grad(w_c[1][3:0], w_x1, w_y0, w_z0);
            r3_g[2] <= pn3d_pkg::grad(w_c[2][3:0], w_x0, w_y1, w_z0);
            r3_g[3] <= pn3d_pkg::grad(w_c[3][3:0], w_x1, w_y1, w_z0);
            r3_g[4] <= pn3d_pkg::grad(w_c[4][3:0], w_x0, w_y0, w_z1);
            r3_g[5] <= pn3d_pkg::grad(w_c[5][3:0], w_x1, w_y0, w_z1);
            r3_g[6] <= pn3d_pkg::grad(w_c[6][3:0], w_x0, w_y1, w_z1);
            r3_g[7] <= pn3d_pkg::grad(w_c[7][3:0], w_x1, w_y1, w_z1);
            // fade outputs line up with S3 results
            for (int k = 0; k < 4; k++) begin
                r4_l[k] <= lerp(LW'(r3_g[2*k]), LW'(r3_g[2*k+1]), w_fx);
            end
            r4_fy <= w_fy;
            r4_fz <= w_fz;
            r5_l[0] <= lerp(r4_l[0], r4_l[1], r4_fy);
            r5_l[1] <= lerp(r4_l[2], r4_l[3], r4_fy);
            r5_fz <= r4_fz;
            r6_l  <= w_r;
            if (r6_l > LW'(131071))       o_noise_value <= 18'sd131071;
            else if (r6_l < -LW'(131072)) o_noise_value <= -18'sd131072;
            else                          o_noise_value <= r6_l[17:0];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pn3d_checker.sv -----
//------------------------------------------------------------------------------
// pn3d_checker
// Port-level assertions for perlin_noise_3d, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_3d_defines.svh"
module pn3d_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic signed [17:0] o_noise_value
);
    `PN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_noise_value), "held beat changed")
    `PN_ASSERT(a_stall_src, i_clk, i_rst_n, !o_stall || (o_valid && i_stall), "input stalled without output stall")
    `PN_ASSERT(a_empty_open, i_clk, i_rst_n, o_valid || !o_stall, "input stalled with empty output")
endmodule
bind perlin_noise_3d pn3d_checker u_chk (.*);
`default_nettype wire
